// ----- design/usb_config_descriptor_msd_finder_defines.svh -----
// assertion macros used by the checker file ucd_checker.sv
`ifndef USB_CONFIG_DESCRIPTOR_MSD_FINDER_DEFINES_SVH
`define USB_CONFIG_DESCRIPTOR_MSD_FINDER_DEFINES_SVH

// clocked check, switched off while reset is asserted
`define UCD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also runs during reset
`define UCD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/ucd_pkg.sv -----
`timescale 1ns / 1ps

package ucd_pkg;

    // descriptor types and minimum lengths
    localparam logic [7:0] TYPE_INTERFACE = 8'd4;
    localparam logic [7:0] TYPE_ENDPOINT  = 8'd5;
    localparam logic [7:0] IFACE_MIN_LEN  = 8'd9;
    localparam logic [7:0] EP_MIN_LEN     = 8'd7;
    localparam logic [7:0] DESC_MIN_LEN   = 8'd2;

    // byte offsets inside a descriptor
    localparam logic [7:0] OFS_LENGTH    = 8'd0;
    localparam logic [7:0] OFS_TYPE      = 8'd1;
    localparam logic [7:0] OFS_CLASS     = 8'd5;
    localparam logic [7:0] OFS_SUBCLASS  = 8'd6;
    localparam logic [7:0] OFS_PROTOCOL  = 8'd7;
    localparam logic [7:0] OFS_EP_ADDR   = 8'd2;
    localparam logic [7:0] OFS_EP_ATTR   = 8'd3;
    localparam logic [7:0] OFS_EP_PKT_LO = 8'd4;
    localparam logic [7:0] OFS_EP_PKT_HI = 8'd5;

    // endpoint fields
    localparam logic [1:0] ATTR_BULK   = 2'd2;
    localparam int         DIR_IN_BIT  = 7;
    localparam logic [2:0] CODE_ALL    = 3'b111;

    // match register reset values
    localparam logic [7:0] RST_MATCH_CLASS    = 8'h08;
    localparam logic [7:0] RST_MATCH_SUBCLASS = 8'h06;
    localparam logic [7:0] RST_MATCH_PROTOCOL = 8'h50;

    // register indexes of the configuration port
    typedef enum logic [1:0] {
        CFG_MATCH_CLASS    = 2'd0,
        CFG_MATCH_SUBCLASS = 2'd1,
        CFG_MATCH_PROTOCOL = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] desc_byte;
        logic       final_byte;
    } desc_item_t;

    typedef struct packed {
        logic        found;
        logic [3:0]  in_endpoint;
        logic [15:0] in_packet_size;
        logic [6:0]  out_endpoint;
        logic [15:0] out_packet_size;
    } res_item_t;

    typedef struct packed {
        logic [7:0] match_class;
        logic [7:0] match_subclass;
        logic [7:0] match_protocol;
    } match_cfg_t;

endpackage

// ----- design/ucd_parser.sv -----
`timescale 1ns / 1ps

module ucd_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  ucd_pkg::desc_item_t desc,
    input  ucd_pkg::match_cfg_t cfg,
    output ucd_pkg::res_item_t  result
);
    import ucd_pkg::*;

    logic [7:0]  byte_offset_reg, byte_offset_next;
    logic [7:0]  cur_length_reg, cur_length_next;
    logic [7:0]  cur_type_reg, cur_type_next;
    logic        halted_reg, halted_next;
    logic        in_match_reg, in_match_next;
    logic [2:0]  code_match_reg, code_match_next;
    logic [7:0]  staged_addr_reg, staged_addr_next;
    logic [1:0]  staged_attr_reg, staged_attr_next;
    logic [15:0] staged_pkt_reg, staged_pkt_next;
    logic [3:0]  held_in_ep_reg, held_in_ep_next;
    logic [15:0] held_in_pkt_reg, held_in_pkt_next;
    logic [6:0]  held_out_ep_reg, held_out_ep_next;
    logic [15:0] held_out_pkt_reg, held_out_pkt_next;

    logic [7:0] b;
    logic       desc_done;

    assign b = desc.desc_byte;

    // field capture, descriptor end and commit
    always_comb
    begin
        byte_offset_next  = byte_offset_reg;
        cur_length_next   = cur_length_reg;
        cur_type_next     = cur_type_reg;
        halted_next       = halted_reg;
        in_match_next     = in_match_reg;
        code_match_next   = code_match_reg;
        staged_addr_next  = staged_addr_reg;
        staged_attr_next  = staged_attr_reg;
        staged_pkt_next   = staged_pkt_reg;
        held_in_ep_next   = held_in_ep_reg;
        held_in_pkt_next  = held_in_pkt_reg;
        held_out_ep_next  = held_out_ep_reg;
        held_out_pkt_next = held_out_pkt_reg;
        desc_done         = 1'b0;

        if (!halted_reg)
        begin
            if (byte_offset_reg == OFS_LENGTH)
            begin
                cur_length_next  = b;
                cur_type_next    = '0;
                code_match_next  = '0;
                staged_addr_next = '0;
                staged_attr_next = '0;
                staged_pkt_next  = '0;
            end
            else if (byte_offset_reg == OFS_TYPE)
            begin
                cur_type_next = b;
            end
            else if (cur_type_reg == TYPE_INTERFACE)
            begin
                if (byte_offset_reg == OFS_CLASS && b == cfg.match_class)
                    code_match_next[0] = 1'b1;
                if (byte_offset_reg == OFS_SUBCLASS && b == cfg.match_subclass)
                    code_match_next[1] = 1'b1;
                if (byte_offset_reg == OFS_PROTOCOL && b == cfg.match_protocol)
                    code_match_next[2] = 1'b1;
            end
            else if (cur_type_reg == TYPE_ENDPOINT)
            begin
                if (byte_offset_reg == OFS_EP_ADDR)
                    staged_addr_next = b;
                if (byte_offset_reg == OFS_EP_ATTR)
                    staged_attr_next = b[1:0];
                if (byte_offset_reg == OFS_EP_PKT_LO)
                    staged_pkt_next[7:0] = b;
                if (byte_offset_reg == OFS_EP_PKT_HI)
                    staged_pkt_next[15:8] = b;
            end

            // a length below two stops parsing for the rest of the buffer
            if (byte_offset_reg == OFS_LENGTH && b < DESC_MIN_LEN)
            begin
                halted_next = 1'b1;
            end
            else if (({1'b0, byte_offset_reg} + 9'd1) >= {1'b0, cur_length_next})
            begin
                desc_done        = 1'b1;
                byte_offset_next = '0;
            end
            else
            begin
                byte_offset_next = byte_offset_reg + 8'd1;
            end

            // commit the descriptor once its last byte is in
            if (desc_done)
            begin
                if (cur_type_next == TYPE_INTERFACE)
                begin
                    in_match_next = (cur_length_next >= IFACE_MIN_LEN) &&
                                    (code_match_next == CODE_ALL);
                end
                else if (cur_type_next == TYPE_ENDPOINT && in_match_reg &&
                         cur_length_next >= EP_MIN_LEN && staged_attr_next == ATTR_BULK)
                begin
                    if (staged_addr_next[DIR_IN_BIT])
                    begin
                        held_in_ep_next  = staged_addr_next[3:0];
                        held_in_pkt_next = staged_pkt_next;
                    end
                    else
                    begin
                        held_out_ep_next  = staged_addr_next[6:0];
                        held_out_pkt_next = staged_pkt_next;
                    end
                end
            end
        end
    end

    // result as it stands after this byte
    always_comb
    begin
        result.found           = (held_in_ep_next != '0) && (held_out_ep_next != '0);
        result.in_endpoint     = held_in_ep_next;
        result.in_packet_size  = held_in_pkt_next;
        result.out_endpoint    = held_out_ep_next;
        result.out_packet_size = held_out_pkt_next;
    end

    // parser state, cleared after the final byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_offset_reg  <= '0;
            cur_length_reg   <= '0;
            cur_type_reg     <= '0;
            halted_reg       <= 1'b0;
            in_match_reg     <= 1'b0;
            code_match_reg   <= '0;
            staged_addr_reg  <= '0;
            staged_attr_reg  <= '0;
            staged_pkt_reg   <= '0;
            held_in_ep_reg   <= '0;
            held_in_pkt_reg  <= '0;
            held_out_ep_reg  <= '0;
            held_out_pkt_reg <= '0;
        end
        else if (take)
        begin
            if (desc.final_byte)
            begin
                byte_offset_reg  <= '0;
                cur_length_reg   <= '0;
                cur_type_reg     <= '0;
                halted_reg       <= 1'b0;
                in_match_reg     <= 1'b0;
                code_match_reg   <= '0;
                staged_addr_reg  <= '0;
                staged_attr_reg  <= '0;
                staged_pkt_reg   <= '0;
                held_in_ep_reg   <= '0;
                held_in_pkt_reg  <= '0;
                held_out_ep_reg  <= '0;
                held_out_pkt_reg <= '0;
            end
            else
            begin
                byte_offset_reg  <= byte_offset_next;
                cur_length_reg   <= cur_length_next;
                cur_type_reg     <= cur_type_next;
                halted_reg       <= halted_next;
                in_match_reg     <= in_match_next;
                code_match_reg   <= code_match_next;
                staged_addr_reg  <= staged_addr_next;
                staged_attr_reg  <= staged_attr_next;
                staged_pkt_reg   <= staged_pkt_next;
                held_in_ep_reg   <= held_in_ep_next;
                held_in_pkt_reg  <= held_in_pkt_next;
                held_out_ep_reg  <= held_out_ep_next;
                held_out_pkt_reg <= held_out_pkt_next;
            end
        end
    end

endmodule

// ----- design/usb_config_descriptor_msd_finder.sv -----
`timescale 1ns / 1ps
// the result item is registered when the final byte is accepted and is valid from the next cycle
// throughput: one descriptor byte per cycle while desc_stall is low, as the parser updates on every accepted byte
// a final byte waits only while the previous result is still held in the output register
// reset (rst_n low, asynchronous): parser state clears, match registers return to
// class 0x08, subclass 0x06, protocol 0x50, no result is pending

module usb_config_descriptor_msd_finder (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                desc_valid,
    output logic                desc_stall,
    input  ucd_pkg::desc_item_t desc,
    output logic                res_valid,
    input  logic                res_stall,
    output ucd_pkg::res_item_t  res,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [7:0]          cfg_data
);
    import ucd_pkg::*;

    match_cfg_t cfg_reg;
    logic       res_valid_reg;
    res_item_t  res_reg;
    res_item_t  res_next;
    logic       take;

    // non-final bytes flow even while a result waits
    assign desc_stall = res_valid_reg && res_stall && desc.final_byte;
    assign take       = desc_valid && !desc_stall;
    assign cfg_ready  = 1'b1;

    ucd_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (take),
        .desc   (desc),
        .cfg    (cfg_reg),
        .result (res_next)
    );

    // match registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.match_class    <= RST_MATCH_CLASS;
            cfg_reg.match_subclass <= RST_MATCH_SUBCLASS;
            cfg_reg.match_protocol <= RST_MATCH_PROTOCOL;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MATCH_CLASS:    cfg_reg.match_class    <= cfg_data;
                CFG_MATCH_SUBCLASS: cfg_reg.match_subclass <= cfg_data;
                CFG_MATCH_PROTOCOL: cfg_reg.match_protocol <= cfg_data;
                default:            cfg_reg                <= cfg_reg;
            endcase
        end
    end

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (take && desc.final_byte)
            res_valid_reg <= 1'b1;
        else if (!res_stall)
            res_valid_reg <= 1'b0;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (take && desc.final_byte)
            res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ----- design/ucd_checker.sv -----
`timescale 1ns / 1ps
`include "usb_config_descriptor_msd_finder_defines.svh"

module ucd_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                desc_valid,
    input logic                desc_stall,
    input ucd_pkg::desc_item_t desc,
    input logic                res_valid,
    input logic                res_stall,
    input ucd_pkg::res_item_t  res
);
    import ucd_pkg::*;

    // a held result keeps its value
    `UCD_ASSERT(a_res_hold, clk, rst_n, res_valid && res_stall |=> res_valid && $stable(res), "result changed while stalled")

    // found agrees with the endpoints it reports
    `UCD_ASSERT(a_found, clk, rst_n, res_valid |-> (res.found == ((res.in_endpoint != 4'd0) && (res.out_endpoint != 7'd0))), "found flag inconsistent")

    // a new result only follows an accepted final byte
    `UCD_ASSERT(a_res_cause, clk, rst_n, res_valid && !$past(res_valid && res_stall) |-> $past(desc_valid && !desc_stall && desc.final_byte), "result without final byte")

    // a final byte is not taken over a waiting result
    `UCD_ASSERT(a_no_overrun, clk, rst_n, desc_valid && desc.final_byte && res_valid && res_stall |-> desc_stall, "final byte taken over held result")

    // nothing is offered once reset has been seen at a clock edge
    `UCD_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !res_valid, "result valid during reset")

endmodule

bind usb_config_descriptor_msd_finder ucd_checker u_ucd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .desc_valid (desc_valid),
    .desc_stall (desc_stall),
    .desc       (desc),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res        (res)
);
